[rtl/h2fs_pkg.sv]
// Shared types, constants and the preface table for the HTTP/2 frame sniffer.
`timescale 1ns / 1ps

package h2fs_pkg;

   // Sizes of the preface and of one frame header, in bytes
   localparam int unsigned PREFACE_LEN = 24;
   localparam int unsigned HEADER_LEN  = 9;

   // Byte offset counter: saturates well past preface plus header
   localparam int unsigned OFF_W = 6;
   localparam int unsigned CNT_W = OFF_W + 1;
   localparam logic [OFF_W-1:0] OFFSET_MAX = {OFF_W{1'b1}};

   // Field widths
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned PORT_W = 16;
   localparam int unsigned LEN_W  = 24;
   localparam int unsigned SID_W  = 31;

   // Stream widths
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 80;

   // Control register port
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;

   // Register reset values
   localparam logic [PORT_W-1:0] PORT_ONE_RST   = 16'd80;
   localparam logic [PORT_W-1:0] PORT_TWO_RST   = 16'd8080;
   localparam logic [PORT_W-1:0] PORT_THREE_RST = 16'd443;
   localparam logic [PORT_W-1:0] PORT_FOUR_RST  = 16'd8443;
   localparam logic [LEN_W-1:0]  MAX_LEN_RST    = 24'h100000;

   // Frame types accepted without a preface
   localparam logic [BYTE_W-1:0] FTYPE_HEADERS  = 8'h01;
   localparam logic [BYTE_W-1:0] FTYPE_SETTINGS = 8'h04;

   // Reserved bit of the stream identifier is dropped
   localparam logic [BYTE_W-1:0] SID_TOP_MASK = 8'h7F;

   // Client connection preface, zero padded to 32 entries
   localparam logic [BYTE_W-1:0] PREFACE_TEXT [32] = '{
      8'h50, 8'h52, 8'h49, 8'h20, 8'h2A, 8'h20, 8'h48, 8'h54,
      8'h54, 8'h50, 8'h2F, 8'h32, 8'h2E, 8'h30, 8'h0D, 8'h0A,
      8'h0D, 8'h0A, 8'h53, 8'h4D, 8'h0D, 8'h0A, 8'h0D, 8'h0A,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PORT_ONE   = 3'd0,
      CSR_PORT_TWO   = 3'd1,
      CSR_PORT_THREE = 3'd2,
      CSR_PORT_FOUR  = 3'd3,
      CSR_MAX_LEN    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PORT_W-1:0] port_one;
      logic [PORT_W-1:0] port_two;
      logic [PORT_W-1:0] port_three;
      logic [PORT_W-1:0] port_four;
      logic [LEN_W-1:0]  max_frame_length;
   } csr_cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_byte;
      logic              last_byte;
      logic              is_tcp;
      logic [PORT_W-1:0] source_port;
      logic [PORT_W-1:0] dest_port;
   } req_item_type;

   // Declared top down so that detected lands in bit 0
   typedef struct packed {
      logic [SID_W-1:0]  stream_id;
      logic [BYTE_W-1:0] frame_flags;
      logic [BYTE_W-1:0] frame_type;
      logic [LEN_W-1:0]  frame_length;
      logic              frame_present;
      logic              preface_seen;
      logic              detected;
   } rsp_item_type;

   // Handshake between parser and output stage
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctl_type;

endpackage

[rtl/h2fs_csr.sv]
// Control registers: plausible ports and frame length limit.
`timescale 1ns / 1ps

module h2fs_csr
   import h2fs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output csr_cfg_type           cfg
);

   csr_cfg_type cfg_ff;
   csr_cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PORT_ONE:   cfg_in.port_one         = csr_wdata[PORT_W-1:0];
            CSR_PORT_TWO:   cfg_in.port_two         = csr_wdata[PORT_W-1:0];
            CSR_PORT_THREE: cfg_in.port_three       = csr_wdata[PORT_W-1:0];
            CSR_PORT_FOUR:  cfg_in.port_four        = csr_wdata[PORT_W-1:0];
            CSR_MAX_LEN:    cfg_in.max_frame_length = csr_wdata[LEN_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.port_one         <= PORT_ONE_RST;
         cfg_ff.port_two         <= PORT_TWO_RST;
         cfg_ff.port_three       <= PORT_THREE_RST;
         cfg_ff.port_four        <= PORT_FOUR_RST;
         cfg_ff.max_frame_length <= MAX_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/h2fs_out_stage.sv]
// Result register toward the rsp stream.
`timescale 1ns / 1ps

module h2fs_out_stage
   import h2fs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  rsp_item_type          res,
   output logic                  advance,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type res_ff;

   // Upstream may move whenever this register is empty or drains now
   assign advance = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(rsp_item_type))'(0), res_ff};

endmodule

[rtl/h2fs_parser.sv]
// Input register, per-packet tracking state and frame header decode.
`timescale 1ns / 1ps

module h2fs_parser
   import h2fs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  csr_cfg_type  cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   input  logic         advance,
   output stage_ctl_type ctl,
   output rsp_item_type res
);

   localparam logic [OFF_W-1:0] PL_OFF  = OFF_W'(PREFACE_LEN);
   localparam logic [CNT_W-1:0] PL_CNT  = CNT_W'(PREFACE_LEN);
   localparam logic [CNT_W-1:0] HDR_CNT = CNT_W'(HEADER_LEN);
   localparam logic [CNT_W-1:0] END_CNT = CNT_W'(PREFACE_LEN + HEADER_LEN);

   // Input register
   logic         s0_valid_ff;
   logic         s0_valid_in;
   req_item_type s0_item_ff;

   // Packet state
   logic [OFF_W-1:0]  off_ff;
   logic [OFF_W-1:0]  off_in;
   logic              pre_ff;
   logic              pre_in;
   logic              port_ff;
   logic              port_in;
   logic [BYTE_W-1:0] hs_ff [HEADER_LEN];
   logic [BYTE_W-1:0] hs_in [HEADER_LEN];
   logic [BYTE_W-1:0] hp_ff [HEADER_LEN];
   logic [BYTE_W-1:0] hp_in [HEADER_LEN];

   // Working values for the byte in the input register
   logic              proc;
   logic [OFF_W-1:0]  off_cur;
   logic              pre_cur;
   logic              port_cur;
   logic              pre_new;
   logic [OFF_W-1:0]  off_inc;
   logic [CNT_W-1:0]  cnt;
   logic              saw;
   logic              hdr_ok;
   logic              listed_src;
   logic              listed_dst;
   logic [BYTE_W-1:0] h [HEADER_LEN];
   logic [LEN_W-1:0]  f_len;
   logic              type_ok;
   rsp_item_type      res_c;

   // Input register transfer control
   assign proc     = s0_valid_ff && advance;
   assign in_ready = advance || !s0_valid_ff;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (in_valid && in_ready) begin
         s0_valid_in = 1'b1;
      end else if (proc) begin
         s0_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s0_item_ff <= in_item;
      end
   end

   // Port plausibility, sampled on a first byte
   assign listed_src = (s0_item_ff.source_port == cfg.port_one)
                    || (s0_item_ff.source_port == cfg.port_two)
                    || (s0_item_ff.source_port == cfg.port_three)
                    || (s0_item_ff.source_port == cfg.port_four);
   assign listed_dst = (s0_item_ff.dest_port == cfg.port_one)
                    || (s0_item_ff.dest_port == cfg.port_two)
                    || (s0_item_ff.dest_port == cfg.port_three)
                    || (s0_item_ff.dest_port == cfg.port_four);

   // Offset, preface match and header capture for this byte
   always_comb begin
      off_cur  = s0_item_ff.first_byte ? '0 : off_ff;
      pre_cur  = s0_item_ff.first_byte ? 1'b1 : pre_ff;
      port_cur = s0_item_ff.first_byte ? (s0_item_ff.is_tcp && (listed_src || listed_dst))
                                       : port_ff;
      pre_new  = pre_cur;
      if ((off_cur < PL_OFF) && (s0_item_ff.data_byte != PREFACE_TEXT[off_cur[4:0]])) begin
         pre_new = 1'b0;
      end
      off_inc = (off_cur == OFFSET_MAX) ? off_cur : off_cur + OFF_W'(1);
      hs_in = hs_ff;
      hp_in = hp_ff;
      for (int i = 0; i < HEADER_LEN; i++) begin
         if (off_cur == OFF_W'(i)) begin
            hs_in[i] = s0_item_ff.data_byte;
         end
         if (off_cur == OFF_W'(PREFACE_LEN + i)) begin
            hp_in[i] = s0_item_ff.data_byte;
         end
      end
      // A last byte closes the packet
      off_in  = s0_item_ff.last_byte ? '0 : off_inc;
      pre_in  = s0_item_ff.last_byte ? 1'b1 : pre_new;
      port_in = port_cur;
   end

   // Classification and header decode on the last byte
   always_comb begin
      cnt    = {1'b0, off_cur} + CNT_W'(1);
      saw    = pre_new && (cnt >= PL_CNT);
      hdr_ok = saw ? (cnt >= END_CNT) : (cnt >= HDR_CNT);
      for (int i = 0; i < HEADER_LEN; i++) begin
         h[i] = saw ? hp_in[i] : hs_in[i];
      end
      f_len   = {h[0], h[1], h[2]};
      type_ok = (h[3] == FTYPE_HEADERS) || (h[3] == FTYPE_SETTINGS);
      res_c   = '0;
      if (port_cur && (cnt >= HDR_CNT)) begin
         if (hdr_ok) begin
            if (saw || ((f_len <= cfg.max_frame_length) && type_ok)) begin
               res_c.detected      = 1'b1;
               res_c.preface_seen  = saw;
               res_c.frame_present = 1'b1;
               res_c.frame_length  = f_len;
               res_c.frame_type    = h[3];
               res_c.frame_flags   = h[4];
               res_c.stream_id     = {h[5][6:0] & SID_TOP_MASK[6:0], h[6], h[7], h[8]};
            end
         end else if (saw) begin
            res_c.detected     = 1'b1;
            res_c.preface_seen = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff  <= '0;
         pre_ff  <= 1'b1;
         port_ff <= 1'b0;
      end else if (proc) begin
         off_ff  <= off_in;
         pre_ff  <= pre_in;
         port_ff <= port_in;
      end
   end

   // Captured header bytes carry no reset
   always_ff @(posedge clock) begin
      if (proc) begin
         hs_ff <= hs_in;
         hp_ff <= hp_in;
      end
   end

   assign ctl.valid   = proc && s0_item_ff.last_byte;
   assign ctl.advance = proc;
   assign res         = res_c;

`ifndef SYNTHESIS
   // Packet state returns to its start after a last byte
   a_close: assert property (@(posedge clock) disable iff (reset)
      (proc && s0_item_ff.last_byte) |=> (off_ff == '0) && pre_ff)
      else $error("packet state not restored after last byte");

   // A held item stays put in the input register
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (s0_valid_ff && !advance) |=> s0_valid_ff && $stable(s0_item_ff))
      else $error("input register changed while stalled");

   // A miss carries an all-zero result
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (ctl.valid && !res.detected) |-> (res == '0))
      else $error("undetected result has nonzero fields");

   // Detection needs a plausible port
   a_port: assert property (@(posedge clock) disable iff (reset)
      (ctl.valid && res.detected) |-> port_cur)
      else $error("detected without plausible port");

   // Without a preface only HEADERS or SETTINGS pass
   a_type: assert property (@(posedge clock) disable iff (reset)
      (ctl.valid && res.frame_present && !res.preface_seen)
         |-> ((res.frame_type == FTYPE_HEADERS) || (res.frame_type == FTYPE_SETTINGS)))
      else $error("frame type check bypassed");
`endif

endmodule

[rtl/http2_frame_sniffer_core.sv]
// Top level of the HTTP/2 frame sniffer: classifies TCP payload byte streams.
`timescale 1ns / 1ps

//  channel | direction | transfer
//  --------+-----------+-------------------------------------------------
//  req_    | in        | one payload byte plus first/last marks and ports
//  rsp_    | out       | one classification per packet, on its last byte
//  csr_    | in        | single-cycle register write, no read-back
//
//  One byte is taken every cycle while req_tready is high; a byte passes
//  through the input register and its result into the output register.
//  rsp_tvalid rises once the result of a last byte is loaded into the
//  output register, and the rsp transfer follows when rsp_tready is high.
//  Reset (synchronous, high) clears the pipeline valids, the packet state
//  and restores the register defaults; captured header bytes are not cleared.
//  A stalled rsp holds the output register; req_tready drops only when a
//  byte waits in the input register behind that stall.

module http2_frame_sniffer_core
   import h2fs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: data_byte[7:0], source_port[23:8], dest_port[39:24]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: first_byte[0], is_tcp[1]
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tlast,
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: detected[0], preface_seen[1], frame_present[2], frame_length[26:3],
   //        frame_type[34:27], frame_flags[42:35], stream_id[73:43], zero[79:74]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   csr_cfg_type   cfg;
   req_item_type  in_item;
   stage_ctl_type ctl;
   rsp_item_type  res;
   logic          advance;

   // Unpack the request transfer
   assign in_item.data_byte   = req_tdata[7:0];
   assign in_item.source_port = req_tdata[23:8];
   assign in_item.dest_port   = req_tdata[39:24];
   assign in_item.first_byte  = req_tuser[0];
   assign in_item.is_tcp      = req_tuser[1];
   assign in_item.last_byte   = req_tlast;

   h2fs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   h2fs_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .advance  (advance),
      .ctl      (ctl),
      .res      (res)
   );

   h2fs_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (ctl.valid),
      .res        (res),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
